[hdl/pdq_pkg.sv]
`default_nettype none
package pdq_pkg;

    localparam int DEPTH    = 64;
    localparam int DW       = 32;
    localparam int POS_W    = 7;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int GRP_SIZE = 8;
    localparam int N_GRP    = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_INSERT     = 3'd2,
        OP_ERASE      = 3'd3,
        OP_SWAP       = 3'd4,
        OP_READ       = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EQUAL  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_SWP  = 2'd3
    } t_cell_op;

    // broadcast to every cell
    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   pos_k;
        logic [IDX_W-1:0]   pos_a;
        logic [IDX_W-1:0]   pos_b;
        logic [DW-1:0]      data_in;
        logic [DW-1:0]      data_a;
        logic [DW-1:0]      data_b;
    } t_cell_cmd;

endpackage
`default_nettype wire

[hdl/pdq_cell.sv]
`default_nettype none
module pdq_cell (
    input  wire                           i_clk,
    input  pdq_pkg::t_cell_cmd            i_cmd,
    input  wire [pdq_pkg::IDX_W-1:0]      i_index,
    input  wire [pdq_pkg::DW-1:0]         i_left,
    input  wire [pdq_pkg::DW-1:0]         i_right,
    output logic [pdq_pkg::DW-1:0]        o_value,
    output logic [pdq_pkg::DW-1:0]        o_tap_a,
    output logic [pdq_pkg::DW-1:0]        o_tap_b
);
    import pdq_pkg::*;

    logic [DW-1:0] r_val;
    logic [DW-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            CELL_INS: begin
                if (i_index == i_cmd.pos_k) begin
                    n_val = i_cmd.data_in;
                end else if (i_index > i_cmd.pos_k) begin
                    n_val = i_left;
                end
            end
            CELL_DEL: begin
                if (i_index >= i_cmd.pos_k) begin
                    n_val = i_right;
                end
            end
            CELL_SWP: begin
                if (i_index == i_cmd.pos_a) begin
                    n_val = i_cmd.data_b;
                end else if (i_index == i_cmd.pos_b) begin
                    n_val = i_cmd.data_a;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    assign o_tap_a = (i_index == i_cmd.pos_a) ? r_val : '0;
    assign o_tap_b = (i_index == i_cmd.pos_b) ? r_val : '0;

endmodule
`default_nettype wire

[hdl/pdq_gather.sv]
`default_nettype none
module pdq_gather (
    input  wire                      i_clk,
    input  wire [pdq_pkg::DW-1:0]    i_taps [pdq_pkg::DEPTH],
    output logic [pdq_pkg::DW-1:0]   o_value
);
    import pdq_pkg::*;

    logic [DW-1:0] r_grp [N_GRP];
    logic [DW-1:0] n_grp [N_GRP];

    // first level: OR within each group, registered
    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GRP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    always_comb begin
        o_value = '0;
        for (int g = 0; g < N_GRP; g++) begin
            o_value = o_value | r_grp[g];
        end
    end

endmodule
`default_nettype wire

[hdl/positional_deque_engine_core.sv]
`default_nettype none
// The input beat is registered in S_IDLE, the two-level tap gather runs in S_FETCH
// ahead of the cell update, and the result is registered in S_EXEC once the output
// is free. Items are accepted only in S_IDLE, also while a result waits.
// Reset (i_rst_n low, synchronous): element count, sequencer and output valid
// clear; cell contents are not reset.
module positional_deque_engine_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire [2:0]                  i_operation,
    input  wire [pdq_pkg::DW-1:0]      i_value,
    input  wire [pdq_pkg::POS_W-1:0]   i_position_a,
    input  wire [pdq_pkg::POS_W-1:0]   i_position_b,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [pdq_pkg::DW-1:0]     o_read_value,
    output logic [1:0]                 o_status,
    output logic [pdq_pkg::CNT_W-1:0]  o_element_count
);
    import pdq_pkg::*;

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    t_state            r_state;
    t_op               r_op;
    logic [DW-1:0]     r_value;
    logic [POS_W-1:0]  r_pos_a;
    logic [POS_W-1:0]  r_pos_b;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [DW-1:0]     r_read_value;
    t_status           r_status;
    logic [CNT_W-1:0]  r_count_out;

    logic [DW-1:0]     w_val   [DEPTH];
    logic [DW-1:0]     w_tap_a [DEPTH];
    logic [DW-1:0]     w_tap_b [DEPTH];
    logic [DW-1:0]     w_va;
    logic [DW-1:0]     w_vb;

    t_cell_cmd         w_cmd;
    t_cell_op          n_cell_op;
    logic [IDX_W-1:0]  n_pos_k;
    t_status           n_status;
    logic [CNT_W-1:0]  n_count;
    logic [DW-1:0]     n_read_value;

    logic [POS_W-1:0]  w_pa_m1;
    logic [POS_W-1:0]  w_pb_m1;
    logic [CMP_W-1:0]  w_pa_x;
    logic [CMP_W-1:0]  w_pb_x;
    logic [CMP_W-1:0]  w_cnt_x;
    logic              w_full;
    logic              w_pa_bad;
    logic              w_pb_bad;
    logic              w_out_free;
    logic              w_fire;

    assign w_pa_m1  = r_pos_a - POS_W'(1);
    assign w_pb_m1  = r_pos_b - POS_W'(1);
    assign w_pa_x   = CMP_W'(r_pos_a);
    assign w_pb_x   = CMP_W'(r_pos_b);
    assign w_cnt_x  = CMP_W'(r_count);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_pa_bad = (r_pos_a == '0) || (w_pa_x > w_cnt_x);
    assign w_pb_bad = (r_pos_b == '0) || (w_pb_x > w_cnt_x);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = (r_state == S_EXEC) && w_out_free;

    always_comb begin
        n_cell_op    = CELL_HOLD;
        n_pos_k      = '0;
        n_status     = ST_OK;
        n_count      = r_count;
        n_read_value = '0;
        case (r_op)
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cell_op = CELL_INS;
                    n_pos_k   = r_count[IDX_W-1:0];
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cell_op = CELL_INS;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (r_pos_a == POS_W'(1) || r_count == '0) begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_cell_op = CELL_INS;
                        n_count   = r_count + CNT_W'(1);
                    end
                end else if (r_pos_a == '0 || w_pa_x > w_cnt_x + CMP_W'(1)) begin
                    n_status = ST_BADPOS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cell_op = CELL_INS;
                    n_pos_k   = w_pa_m1[IDX_W-1:0];
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_ERASE: begin
                if (w_pa_bad) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_cell_op = CELL_DEL;
                    n_pos_k   = w_pa_m1[IDX_W-1:0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_SWAP: begin
                if (r_pos_a == r_pos_b) begin
                    n_status = ST_EQUAL;
                end else if (w_pa_bad || w_pb_bad) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_cell_op = CELL_SWP;
                end
            end
            OP_READ: begin
                if (w_pa_bad) begin
                    n_status     = ST_BADPOS;
                    n_read_value = (r_count != '0) ? w_val[0] : '0;
                end else begin
                    n_read_value = w_va;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: n_status = ST_BADPOS;
        endcase
    end

    always_comb begin
        w_cmd.op      = w_fire ? n_cell_op : CELL_HOLD;
        w_cmd.pos_k   = n_pos_k;
        w_cmd.pos_a   = w_pa_m1[IDX_W-1:0];
        w_cmd.pos_b   = w_pb_m1[IDX_W-1:0];
        w_cmd.data_in = r_value;
        w_cmd.data_a  = w_va;
        w_cmd.data_b  = w_vb;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DW-1:0] w_left;
            logic [DW-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_val[g];
            end else begin : g_mid_l
                assign w_left = w_val[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_val[g];
            end else begin : g_mid_r
                assign w_right = w_val[g+1];
            end
            pdq_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_index (IDX_W'(g)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_val[g]),
                .o_tap_a (w_tap_a[g]),
                .o_tap_b (w_tap_b[g])
            );
        end
    endgenerate

    pdq_gather u_gather_a (
        .i_clk   (i_clk),
        .i_taps  (w_tap_a),
        .o_value (w_va)
    );

    pdq_gather u_gather_b (
        .i_clk   (i_clk),
        .i_taps  (w_tap_b),
        .o_value (w_vb)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= t_op'(i_operation);
                        r_value <= i_value;
                        r_pos_a <= i_position_a;
                        r_pos_b <= i_position_b;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_count      <= n_count;
                        r_out_valid  <= 1'b1;
                        r_read_value <= n_read_value;
                        r_status     <= n_status;
                        r_count_out  <= n_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_read_value;
    assign o_status        = r_status;
    assign o_element_count = r_count_out;

endmodule
`default_nettype wire
